/* rtl/core/assert_macros.svh */
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is high
`define LBP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// clocked assertion that also holds through reset
`define LBP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/core/lbp_pkg.sv */
// types, codes and helpers for the led blink pattern generator
`default_nettype none

package lbp_pkg;

   localparam int TIME_BITS = 32;
   localparam int NOW_BITS  = 32;
   localparam int DUR_BITS  = 16;
   localparam int LEN_BITS  = 8;
   localparam int MODE_BITS = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [MODE_BITS-1:0] MODE_OFF   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_ON    = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_BLINK = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_BURST = 2'd3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_MODE  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLINK_ON_MS   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLINK_OFF_MS  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BURST_ON_MS   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BURST_OFF_MS  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BURST_LENGTH  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BURST_WAIT_MS = 3'd6;

   localparam logic [LEN_BITS-1:0] CYCLES_MAX = '1;

   typedef struct packed {
      logic [MODE_BITS-1:0] pattern_mode;
      logic [DUR_BITS-1:0]  blink_on_ms;
      logic [DUR_BITS-1:0]  blink_off_ms;
      logic [DUR_BITS-1:0]  burst_on_ms;
      logic [DUR_BITS-1:0]  burst_off_ms;
      logic [LEN_BITS-1:0]  burst_length;
      logic [DUR_BITS-1:0]  burst_wait_ms;
   } lbp_cfg_type;

   typedef struct packed {
      logic                 drive_level;
      logic                 blink_phase_on;
      logic [TIME_BITS-1:0] blink_last_change;
      logic                 burst_phase_on;
      logic [TIME_BITS-1:0] burst_last_change;
      logic [LEN_BITS-1:0]  burst_cycles_done;
      logic                 burst_waiting;
   } lbp_state_type;

   // phase over once now reaches last + dur, sum wraps at the time width
   function automatic logic elapsed(input logic [TIME_BITS-1:0] now,
                                    input logic [DUR_BITS-1:0]  dur,
                                    input logic [TIME_BITS-1:0] last);
      logic [TIME_BITS-1:0] limit;
      limit = last + TIME_BITS'(dur);
      return now >= limit;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/lbp_step.sv */
// next-state logic of the pattern generator for one poll
`default_nettype none

module lbp_step
   import lbp_pkg::*;
(
   input  lbp_cfg_type          cfg,
   input  lbp_state_type        state,
   input  logic [TIME_BITS-1:0] now,
   output lbp_state_type        next_state
);

   logic [LEN_BITS-1:0] cycles_inc;

   assign cycles_inc = (state.burst_cycles_done < CYCLES_MAX) ?
                       state.burst_cycles_done + LEN_BITS'(1) : state.burst_cycles_done;

   always_comb begin
      next_state = state;
      case (cfg.pattern_mode)
         MODE_OFF: begin
            next_state.drive_level = 1'b0;
         end
         MODE_ON: begin
            next_state.drive_level = 1'b1;
         end
         MODE_BLINK: begin
            if (state.blink_phase_on) begin
               if (elapsed(now, cfg.blink_on_ms, state.blink_last_change)) begin
                  next_state.blink_last_change = now;
                  next_state.blink_phase_on    = 1'b0;
                  next_state.drive_level       = 1'b0;
               end
            end else begin
               if (elapsed(now, cfg.blink_off_ms, state.blink_last_change)) begin
                  next_state.blink_last_change = now;
                  next_state.blink_phase_on    = 1'b1;
                  next_state.drive_level       = 1'b1;
               end
            end
         end
         default: begin
            if (state.burst_waiting) begin
               // led held off for the whole wait
               next_state.drive_level = 1'b0;
               if (elapsed(now, cfg.burst_wait_ms, state.burst_last_change)) begin
                  next_state.burst_last_change = now;
                  next_state.burst_cycles_done = '0;
                  next_state.burst_waiting     = 1'b0;
                  next_state.burst_phase_on    = 1'b0;
               end
            end else if (state.burst_phase_on) begin
               if (elapsed(now, cfg.burst_on_ms, state.burst_last_change)) begin
                  next_state.burst_last_change = now;
                  next_state.burst_phase_on    = 1'b0;
                  next_state.drive_level       = 1'b0;
                  next_state.burst_cycles_done = cycles_inc;
                  if (cycles_inc >= cfg.burst_length) begin
                     next_state.burst_waiting = 1'b1;
                  end
               end
            end else begin
               if (elapsed(now, cfg.burst_off_ms, state.burst_last_change)) begin
                  next_state.burst_last_change = now;
                  next_state.burst_phase_on    = 1'b1;
                  next_state.drive_level       = 1'b1;
               end
            end
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/core/led_blink_pattern_generator_unit.sv */
// Drives one LED level from a pattern mode, one poll transaction at a time.
//
// req channel: req_valid / req_stall with req_now_ms, the millisecond time
// of the poll. rsp channel: rsp_valid / rsp_stall with rsp_led_level, the
// level after that poll; exactly one rsp transaction per req transaction,
// in order. csr channel: csr_valid / csr_ready write port, csr_index picks
// the register (mode, blink on/off, burst on/off, burst length, burst wait),
// csr_wdata carries the value; csr_ready is always high. Write registers only
// while no poll is in flight.
// Each poll passes the input register, then the result register. A new poll
// is taken every cycle while the receiver does not stall; the single
// compare-and-update of the phase state sits between the two registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more poll; req_stall rises only once both are full.
// Reset (synchronous, active high) clears the configuration registers and
// phase state to 0, empties both stages and sets the stored drive level to on.
`default_nettype none

module led_blink_pattern_generator_unit
   import lbp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [NOW_BITS-1:0]       req_now_ms,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_led_level,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   lbp_cfg_type          cfg_ff, cfg_in;
   lbp_state_type        state_ff, state_in, state_next;
   logic                 s1_valid_ff, s1_valid_in;
   logic [TIME_BITS-1:0] s1_now_ff, s1_now_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_level_ff, rsp_level_in;
   logic                 move;
   logic                 fire;
   logic                 load;

   assign csr_ready = 1'b1;

   // result register free or being drained this cycle
   assign move      = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !move;
   assign load      = req_valid && !req_stall;
   assign fire      = s1_valid_ff && move;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN_MODE:  cfg_in.pattern_mode  = csr_wdata[MODE_BITS-1:0];
            CSR_BLINK_ON_MS:   cfg_in.blink_on_ms   = csr_wdata[DUR_BITS-1:0];
            CSR_BLINK_OFF_MS:  cfg_in.blink_off_ms  = csr_wdata[DUR_BITS-1:0];
            CSR_BURST_ON_MS:   cfg_in.burst_on_ms   = csr_wdata[DUR_BITS-1:0];
            CSR_BURST_OFF_MS:  cfg_in.burst_off_ms  = csr_wdata[DUR_BITS-1:0];
            CSR_BURST_LENGTH:  cfg_in.burst_length  = csr_wdata[LEN_BITS-1:0];
            CSR_BURST_WAIT_MS: cfg_in.burst_wait_ms = csr_wdata[DUR_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   lbp_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .now        (s1_now_ff),
      .next_state (state_next)
   );

   assign s1_valid_in  = req_stall ? 1'b1 : req_valid;
   assign s1_now_in    = load ? TIME_BITS'(req_now_ms) : s1_now_ff;
   assign state_in     = fire ? state_next : state_ff;
   assign rsp_valid_in = fire ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_level_in = fire ? state_next.drive_level : rsp_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{drive_level: 1'b1, default: '0};
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_now_ff    <= s1_now_in;
      rsp_level_ff <= rsp_level_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_led_level = rsp_level_ff;

endmodule

`default_nettype wire

/* rtl/core/lbp_checker.sv */
// port-level checker for the led blink pattern generator and its bind
`default_nettype none

`include "assert_macros.svh"

module lbp_checker
   import lbp_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic [NOW_BITS-1:0] req_now_ms,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic                rsp_led_level,
   input wire logic                csr_ready
);

   // a stalled result keeps its level
   `LBP_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> $stable(rsp_led_level), "rsp moved")

   // input backpressure only comes from a full, stalled result stage
   `LBP_ASSERT(a_stall_source, req_stall |-> (rsp_valid && rsp_stall), "stray req_stall")

   // an empty result stage fills only from a poll that passed the input register
   `LBP_ASSERT(a_rsp_latency, $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2), "stray rsp")

   // a stalled poll keeps its timestamp
   `LBP_ASSERT(a_req_hold, req_valid && req_stall |=> $stable(req_now_ms), "req moved")

   // register writes are never refused
   `LBP_ASSERT_ALWAYS(a_csr_ready, csr_ready, "csr_ready low")

endmodule

bind led_blink_pattern_generator_unit lbp_checker u_lbp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_now_ms    (req_now_ms),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_led_level (rsp_led_level),
   .csr_ready     (csr_ready)
);

`default_nettype wire

/* sim/led_blink_pattern_generator_unit_tb.sv */
// testbench for the led blink pattern generator: poll, burst and csr checks against a predictor
`timescale 1ns / 1ps

module led_blink_pattern_generator_unit_tb;
   import lbp_pkg::*;

   localparam int POLL_TARGET    = 950;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;

   typedef enum logic [1:0] {ROW_CFG, ROW_POLL_PRED, ROW_POLL_OFF, ROW_POLL_ON} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [NOW_BITS-1:0]       value;
   } dir_row_type;

   localparam int DIR_ROWS = 32;
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      '{ROW_POLL_OFF,  CSR_PATTERN_MODE,  32'h0000_0000},
      '{ROW_POLL_OFF,  CSR_PATTERN_MODE,  32'hFFFF_FFFF},
      '{ROW_CFG,       CSR_PATTERN_MODE,  32'h0000_FFFD},   // upper bits dropped, steady on
      '{ROW_POLL_ON,   CSR_PATTERN_MODE,  32'h0000_0000},
      '{ROW_CFG,       CSR_UNUSED,        32'h0000_FFFF},
      '{ROW_POLL_ON,   CSR_PATTERN_MODE,  32'h0000_3039},
      '{ROW_CFG,       CSR_PATTERN_MODE,  {30'd0, MODE_BLINK}},
      '{ROW_POLL_ON,   CSR_PATTERN_MODE,  32'h0000_0000},
      '{ROW_POLL_OFF,  CSR_PATTERN_MODE,  32'h0000_0000},
      '{ROW_POLL_ON,   CSR_PATTERN_MODE,  32'hFFFF_FFFF},
      '{ROW_CFG,       CSR_BLINK_ON_MS,   32'h0000_FFFF},
      '{ROW_CFG,       CSR_BLINK_OFF_MS,  32'h0000_FFFF},
      '{ROW_POLL_PRED, CSR_PATTERN_MODE,  32'h0000_0064},   // limit wrapped past zero
      '{ROW_POLL_PRED, CSR_PATTERN_MODE,  32'h0001_0000},
      '{ROW_CFG,       CSR_PATTERN_MODE,  {30'd0, MODE_BURST}},
      '{ROW_POLL_ON,   CSR_PATTERN_MODE,  32'h0000_0005},
      '{ROW_POLL_OFF,  CSR_PATTERN_MODE,  32'h0000_0005},   // zero length, wait starts
      '{ROW_POLL_OFF,  CSR_PATTERN_MODE,  32'h0000_0005},
      '{ROW_POLL_ON,   CSR_PATTERN_MODE,  32'h0000_0006},
      '{ROW_CFG,       CSR_PATTERN_MODE,  {30'd0, MODE_OFF}},
      '{ROW_POLL_OFF,  CSR_PATTERN_MODE,  32'h0000_0007},
      '{ROW_CFG,       CSR_BURST_LENGTH,  32'h0000_FFFF},
      '{ROW_CFG,       CSR_BURST_WAIT_MS, 32'h0000_FFFF},
      '{ROW_CFG,       CSR_BURST_ON_MS,   32'h0000_0003},
      '{ROW_CFG,       CSR_BURST_OFF_MS,  32'h0000_0002},
      '{ROW_CFG,       CSR_PATTERN_MODE,  {30'd0, MODE_BLINK}},   // blink resumes its phase
      '{ROW_POLL_PRED, CSR_PATTERN_MODE,  32'h0001_FFFE},
      '{ROW_POLL_PRED, CSR_PATTERN_MODE,  32'h0001_FFFF},
      '{ROW_CFG,       CSR_PATTERN_MODE,  {30'd0, MODE_BURST}},   // burst resumes its phase
      '{ROW_POLL_PRED, CSR_PATTERN_MODE,  32'h0000_0008},
      '{ROW_POLL_PRED, CSR_PATTERN_MODE,  32'h0000_0009},
      '{ROW_POLL_PRED, CSR_PATTERN_MODE,  32'h0000_000B}
   };

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [NOW_BITS-1:0]       req_now_ms;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_led_level;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   // predictor copy of the registers and pattern state
   lbp_cfg_type          cfg;
   logic                 led_now;
   logic                 blink_on_phase;
   logic [TIME_BITS-1:0] blink_stamp;
   logic                 burst_on_phase;
   logic [TIME_BITS-1:0] burst_stamp;
   logic [LEN_BITS-1:0]  burst_count;
   logic                 burst_hold;

   logic level_queue [$];
   int   fail_count;
   int   polls_sent;
   int   levels_checked;
   int   csr_writes;
   int   phase_count;
   int   burst_left;
   int   idle_cycles = 0;
   int   stall_cycle = 0;

   led_blink_pattern_generator_unit uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_now_ms    (req_now_ms),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_led_level (rsp_led_level),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic phase_due(input logic [TIME_BITS-1:0] now,
                                      input logic [DUR_BITS-1:0]  dur,
                                      input logic [TIME_BITS-1:0] stamp);
      logic [TIME_BITS-1:0] deadline;
      deadline = stamp + {{(TIME_BITS-DUR_BITS){1'b0}}, dur};
      return now >= deadline;
   endfunction

   // led level after one poll, updates the predictor state
   function automatic logic predict_led(input logic [TIME_BITS-1:0] now);
      case (cfg.pattern_mode)
         MODE_OFF: led_now = 1'b0;
         MODE_ON:  led_now = 1'b1;
         MODE_BLINK: begin
            if (blink_on_phase) begin
               if (phase_due(now, cfg.blink_on_ms, blink_stamp)) begin
                  blink_stamp    = now;
                  blink_on_phase = 1'b0;
                  led_now        = 1'b0;
               end
            end else if (phase_due(now, cfg.blink_off_ms, blink_stamp)) begin
               blink_stamp    = now;
               blink_on_phase = 1'b1;
               led_now        = 1'b1;
            end
         end
         default: begin
            if (burst_hold) begin
               led_now = 1'b0;
               if (phase_due(now, cfg.burst_wait_ms, burst_stamp)) begin
                  burst_stamp    = now;
                  burst_count    = '0;
                  burst_hold     = 1'b0;
                  burst_on_phase = 1'b0;
               end
            end else if (burst_on_phase) begin
               if (phase_due(now, cfg.burst_on_ms, burst_stamp)) begin
                  burst_stamp    = now;
                  burst_on_phase = 1'b0;
                  led_now        = 1'b0;
                  if (burst_count != CYCLES_MAX)
                     burst_count = burst_count + 1'b1;
                  if (burst_count >= cfg.burst_length)
                     burst_hold = 1'b1;
               end
            end else if (phase_due(now, cfg.burst_off_ms, burst_stamp)) begin
               burst_stamp    = now;
               burst_on_phase = 1'b1;
               led_now        = 1'b1;
            end
         end
      endcase
      return led_now;
   endfunction

   // registers change only with no poll in flight
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0]  data);
      req_valid <= 1'b0;
      while (level_queue.size() != 0)
         @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do
         @(posedge clock);
      while (!csr_ready);
      case (index)
         CSR_PATTERN_MODE:  cfg.pattern_mode  = data[MODE_BITS-1:0];
         CSR_BLINK_ON_MS:   cfg.blink_on_ms   = data;
         CSR_BLINK_OFF_MS:  cfg.blink_off_ms  = data;
         CSR_BURST_ON_MS:   cfg.burst_on_ms   = data;
         CSR_BURST_OFF_MS:  cfg.burst_off_ms  = data;
         CSR_BURST_LENGTH:  cfg.burst_length  = data[LEN_BITS-1:0];
         CSR_BURST_WAIT_MS: cfg.burst_wait_ms = data;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic send_poll(input logic [NOW_BITS-1:0] now, input row_kind_type kind);
      int   gap;
      logic level;
      csr_valid <= 1'b0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid  <= 1'b1;
      req_now_ms <= now;
      do
         @(posedge clock);
      while (req_stall);
      level = predict_led(now);
      case (kind)
         ROW_POLL_OFF: level_queue.push_back(1'b0);
         ROW_POLL_ON:  level_queue.push_back(1'b1);
         default:      level_queue.push_back(level);
      endcase
      polls_sent++;
   endtask

   // receiver stall pattern, rotating through four styles
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      case ((stall_cycle / 97) % 4)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ((stall_cycle % 5) < 2);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (level_queue.size() == 0) begin
            $error("led_level: no transaction expected, got %0b", rsp_led_level);
            fail_count++;
         end else begin
            if (rsp_led_level !== level_queue[0]) begin
               $error("led_level mismatch: expected %0b, actual %0b",
                      level_queue[0], rsp_led_level);
               fail_count++;
            end
            void'(level_queue.pop_front());
            levels_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      logic [NOW_BITS-1:0]      sim_now;
      logic [CSR_DATA_BITS-1:0] data;
      logic [MODE_BITS-1:0]     mode;
      int                       pick;
      int                       phase_polls;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_now_ms     <= '0;
      csr_valid      <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      fail_count     = 0;
      polls_sent     = 0;
      levels_checked = 0;
      csr_writes     = 0;
      phase_count    = 0;
      burst_left     = 0;
      cfg            = '0;
      led_now        = 1'b1;
      blink_on_phase = 1'b0;
      blink_stamp    = '0;
      burst_on_phase = 1'b0;
      burst_stamp    = '0;
      burst_count    = '0;
      burst_hold     = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (DIR_TABLE[i].kind == ROW_CFG)
            write_csr(DIR_TABLE[i].index, DIR_TABLE[i].value[CSR_DATA_BITS-1:0]);
         else
            send_poll(DIR_TABLE[i].value, DIR_TABLE[i].kind);
      end

      sim_now = 32'h0000_0100;
      while (polls_sent < POLL_TARGET) begin
         phase_count++;
         // durations and burst length: mostly short, sometimes zero, max or anything
         for (int idx = CSR_BLINK_ON_MS; idx <= CSR_BURST_WAIT_MS; idx++) begin
            if ($urandom_range(0, 3) != 0) begin
               pick = $urandom_range(0, 9);
               if (idx == CSR_BURST_LENGTH)
                  data = {8'($urandom), (pick == 0) ? 8'd0 : (pick == 1) ? 8'hFF :
                          (pick == 2) ? 8'($urandom) : 8'($urandom_range(1, 4))};
               else
                  data = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                         (pick == 2) ? 16'($urandom) : 16'($urandom_range(1, 6));
               write_csr(CSR_INDEX_BITS'(idx), data);
            end
         end
         if ($urandom_range(0, 7) == 0)
            write_csr(CSR_UNUSED, 16'($urandom));
         pick = $urandom_range(0, 9);
         mode = (pick == 0) ? MODE_OFF : (pick == 1) ? MODE_ON :
                (pick < 5) ? MODE_BLINK : MODE_BURST;
         write_csr(CSR_PATTERN_MODE, {14'($urandom), mode});

         phase_polls = $urandom_range(40, 120);
         repeat (phase_polls) begin
            pick = $urandom_range(0, 49);
            if (pick == 0)
               sim_now = $urandom;
            else if (pick == 1)
               sim_now = 32'hFFFF_FFFF - $urandom_range(0, 20);
            else
               sim_now = sim_now + $urandom_range(0, 3);
            send_poll(sim_now, ROW_POLL_PRED);
         end
      end

      req_valid <= 1'b0;
      while (level_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d poll transactions and %0d csr writes over %0d random phases",
               polls_sent, csr_writes, phase_count);
      $display("%0d led levels compared, %0d failures", levels_checked, fail_count);
      if (fail_count == 0 && level_queue.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
